@@ design/rpbc_pkg.sv @@
`timescale 1ns / 1ps
package rpbc_pkg;

  localparam int ID_W   = 31;
  localparam int CRD_W  = 32;
  localparam int ANG_W  = 16;
  localparam int FRAC_W = 14;
  localparam int WORD_W = ID_W + 2 * CRD_W;
  localparam int DATA_W = ((WORD_W + 7) / 8) * 8;

  localparam logic REG_COS = 1'b0;
  localparam logic REG_SIN = 1'b1;

  typedef struct packed {
    logic signed [CRD_W-1:0] min_x;
    logic signed [CRD_W-1:0] max_x;
    logic signed [CRD_W-1:0] min_y;
    logic signed [CRD_W-1:0] max_y;
  } bbox_t;

  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic                    ovf;
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
  } rot_ctl_t;

endpackage

@@ design/rpbc_ram.sv @@
`timescale 1ns / 1ps
module rpbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/rpbc_loader.sv @@
`timescale 1ns / 1ps
module rpbc_loader #(
  parameter int MAX_POINTS = 64,
  localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic signed [rpbc_pkg::CRD_W-1:0] x_coord,
  input  logic signed [rpbc_pkg::CRD_W-1:0] y_coord,
  input  logic                             clear,
  output rpbc_pkg::bbox_t                  box,
  output logic [CNT_W-1:0]                 count,
  output logic                             dropped,
  output logic                             full
);

  rpbc_pkg::bbox_t  box_r, box_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             drop_r, drop_nxt;

  assign full = (cnt_r == CNT_W'(MAX_POINTS));

  always_comb begin
    box_nxt  = box_r;
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;
    if (clear) begin
      box_nxt  = '0;
      cnt_nxt  = '0;
      drop_nxt = 1'b0;
    end else if (accept) begin
      if (full) begin
        drop_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == '0) begin
          box_nxt.min_x = x_coord;
          box_nxt.max_x = x_coord;
          box_nxt.min_y = y_coord;
          box_nxt.max_y = y_coord;
        end else begin
          if (x_coord < box_r.min_x) box_nxt.min_x = x_coord;
          if (x_coord > box_r.max_x) box_nxt.max_x = x_coord;
          if (y_coord < box_r.min_y) box_nxt.min_y = y_coord;
          if (y_coord > box_r.max_y) box_nxt.max_y = y_coord;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r  <= '0;
      cnt_r  <= '0;
      drop_r <= 1'b0;
    end else begin
      box_r  <= box_nxt;
      cnt_r  <= cnt_nxt;
      drop_r <= drop_nxt;
    end
  end

  assign box     = box_r;
  assign count   = cnt_r;
  assign dropped = drop_r;

endmodule

@@ design/rpbc_rotate.sv @@
`timescale 1ns / 1ps
module rpbc_rotate #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rpbc_pkg::rot_ctl_t                 s1_ctl,
  input  logic [rpbc_pkg::WORD_W-1:0]        s1_word,
  input  logic signed [rpbc_pkg::ANG_W-1:0]  cos_angle,
  input  logic signed [rpbc_pkg::ANG_W-1:0]  sin_angle,
  output logic                               pipe_en,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rpbc_pkg::DATA_W-1:0]        out_tdata,
  output logic                               out_tlast,
  output logic                               out_tuser
);

  localparam int CW = rpbc_pkg::CRD_W;
  localparam int IW = rpbc_pkg::ID_W;
  localparam int DW = CW + 1;
  localparam int PW = DW + rpbc_pkg::ANG_W;
  localparam int SW = PW + 1;
  localparam int HW = SW - rpbc_pkg::FRAC_W;
  localparam int RW = HW + 1;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  function automatic logic [CW-1:0] finish(input logic signed [SW-1:0] s,
                                           input logic signed [CW-1:0] c);
    logic signed [HW-1:0] h;
    logic signed [RW-1:0] r;
    logic signed [63:0]   w;
    h = s[SW-1:rpbc_pkg::FRAC_W];
    r = $signed({h[HW-1], h}) + $signed({{(RW-CW){c[CW-1]}}, c});
    w = {{(64-RW){r[RW-1]}}, r};
    if (w > SAT_HI) w = SAT_HI;
    else if (w < SAT_LO) w = SAT_LO;
    return w[CW-1:0];
  endfunction

  rpbc_pkg::rot_ctl_t   s2_ctl_r, s3_ctl_r;
  logic [IW-1:0]        s2_id_r, s3_id_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic signed [PW-1:0] p_xc_r, p_ys_r, p_yc_r, p_xs_r;
  logic signed [CW-1:0] x_in, y_in;
  logic signed [SW-1:0] sum_x, sum_y;
  logic                 out_valid_r;
  logic [IW-1:0]        out_id_r;
  logic [CW-1:0]        new_x_r, new_y_r;
  logic                 out_last_r, out_ovf_r;

  assign pipe_en = !out_valid_r || out_tready;

  assign x_in = s1_word[IW +: CW];
  assign y_in = s1_word[IW+CW +: CW];

  assign sum_x = p_xc_r + p_ys_r;
  assign sum_y = p_yc_r - p_xs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r    <= '0;
      s3_ctl_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s2_ctl_r    <= s1_ctl;
      s3_ctl_r    <= s2_ctl_r;
      out_valid_r <= s3_ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_id_r    <= s1_word[IW-1:0];
      dx_r       <= $signed({x_in[CW-1], x_in}) - $signed({s1_ctl.cx[CW-1], s1_ctl.cx});
      dy_r       <= $signed({y_in[CW-1], y_in}) - $signed({s1_ctl.cy[CW-1], s1_ctl.cy});
      s3_id_r    <= s2_id_r;
      p_xc_r     <= dx_r * cos_angle;
      p_ys_r     <= dy_r * sin_angle;
      p_yc_r     <= dy_r * cos_angle;
      p_xs_r     <= dx_r * sin_angle;
      out_id_r   <= s3_id_r;
      new_x_r    <= finish(sum_x, s3_ctl_r.cx);
      new_y_r    <= finish(sum_y, s3_ctl_r.cy);
      out_last_r <= s3_ctl_r.last;
      out_ovf_r  <= s3_ctl_r.ovf;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(rpbc_pkg::DATA_W - rpbc_pkg::WORD_W){1'b0}},
                       new_y_r, new_x_r, out_id_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

@@ design/rotate_points_about_bbox_center.sv @@
`timescale 1ns / 1ps
// rotate points about the center of their bounding box
// in_*: point transactions, one per cycle while loading; tlast closes a set.
// out_*: rotated points in load order; tlast on the final one, tuser set
//   on every point of a set that lost points beyond MAX_POINTS.
// cfg_*: cos (index 0) and sin (index 1), signed Q2.14, write when idle.
// after the last point a center state forms the center from the bounding
// box, then the point memory is read one entry per cycle unless out_tready
// stalls; each read passes the memory read register, a subtract stage, a
// multiply stage and the output register, and a set streams out one
// result per cycle while out_tready does not stall.
// in_tready is low after the last point through the center state and the
// memory walk; the next set loads while the tail is still in the pipe.
// a stall on out_tready freezes the memory read port and every stage.
// reset empties the set, clears the bounding box, sets cos to 1.0 and sin
// to 0, and drops results in flight. no clearing pass is needed.
module rotate_points_about_bbox_center #(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [rpbc_pkg::DATA_W-1:0]  in_tdata,   // point_id, x_coord, y_coord, pad
  input  logic                         in_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [rpbc_pkg::DATA_W-1:0]  out_tdata,  // out_id, new_x, new_y, pad
  output logic                         out_tlast,
  output logic                         out_tuser,  // overflowed
  input  logic                         cfg_wr_en,
  input  logic                         cfg_addr,
  input  logic [rpbc_pkg::ANG_W-1:0]   cfg_wdata
);

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW     = rpbc_pkg::CRD_W;
  localparam int IW     = rpbc_pkg::ID_W;

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_CENTER = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0]                       state_r, state_nxt;
  logic signed [rpbc_pkg::ANG_W-1:0] cos_r, sin_r;
  logic [ADDR_W-1:0]                rd_idx_r, rd_idx_nxt;
  logic [ADDR_W-1:0]                last_idx_r;
  logic signed [CW-1:0]             cx_r, cy_r;
  logic                             ovf_r;
  rpbc_pkg::rot_ctl_t               s1_ctl_r;
  rpbc_pkg::bbox_t                  box;
  logic [CNT_W-1:0]                 count, count_m1;
  logic                             dropped, full;
  logic                             in_acc, clear, issue, pipe_en;
  logic [rpbc_pkg::WORD_W-1:0]      rd_word;
  logic signed [CW:0]               sum_x, sum_y;

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign clear     = (state_r == ST_CENTER);
  assign issue     = (state_r == ST_EMIT) && pipe_en;
  assign count_m1  = count - CNT_W'(1);

  assign sum_x = $signed({box.max_x[CW-1], box.max_x}) + $signed({box.min_x[CW-1], box.min_x});
  assign sum_y = $signed({box.max_y[CW-1], box.max_y}) + $signed({box.min_y[CW-1], box.min_y});

  rpbc_loader #(
    .MAX_POINTS (MAX_POINTS)
  ) u_loader (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_acc),
    .x_coord (in_tdata[IW +: CW]),
    .y_coord (in_tdata[IW+CW +: CW]),
    .clear   (clear),
    .box     (box),
    .count   (count),
    .dropped (dropped),
    .full    (full)
  );

  rpbc_ram #(
    .WIDTH (rpbc_pkg::WORD_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_acc && !full),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (in_tdata[rpbc_pkg::WORD_W-1:0]),
    .rd_en   (pipe_en),
    .rd_addr (rd_idx_r),
    .rd_data (rd_word)
  );

  rpbc_rotate #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_rotate (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_ctl     (s1_ctl_r),
    .s1_word    (rd_word),
    .cos_angle  (cos_r),
    .sin_angle  (sin_r),
    .pipe_en    (pipe_en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always_comb begin
    state_nxt  = state_r;
    rd_idx_nxt = rd_idx_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_tlast) state_nxt = ST_CENTER;
      end
      ST_CENTER: begin
        rd_idx_nxt = '0;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + ADDR_W'(1);
          if (rd_idx_r == last_idx_r) state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      rd_idx_r <= '0;
      cos_r    <= 16'sd16384;
      sin_r    <= '0;
      s1_ctl_r <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
      if (cfg_wr_en) begin
        case (cfg_addr)
          rpbc_pkg::REG_COS: cos_r <= cfg_wdata;
          rpbc_pkg::REG_SIN: sin_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (pipe_en) begin
        s1_ctl_r.valid <= issue;
        s1_ctl_r.last  <= (rd_idx_r == last_idx_r);
        s1_ctl_r.ovf   <= ovf_r;
        s1_ctl_r.cx    <= cx_r;
        s1_ctl_r.cy    <= cy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      cx_r       <= sum_x[CW:1];
      cy_r       <= sum_y[CW:1];
      ovf_r      <= dropped;
      last_idx_r <= count_m1[ADDR_W-1:0];
    end
  end

endmodule
